>>> design/pllnco_pkg.sv
// shared types, constants and tables for the pilot pll with scaled nco
package pllnco_pkg;

   // fixed geometry of the loop
   localparam int SAMPLE_BITS  = 16;
   localparam int PHASE_BITS   = 32;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_BITS    = $clog2(CORDIC_STEPS);

   // configuration register widths
   localparam int STEP_W   = 31;
   localparam int BW_W     = 16;
   localparam int SCALE_W  = 4;
   localparam int ADJUST_W = 16;
   localparam int CSR_W    = 31;
   localparam int CSR_A_W  = 2;

   // cordic datapath width, multiplier operand and product widths
   localparam int CW     = 34;
   localparam int MA_W   = 34;
   localparam int MB_W   = 19;
   localparam int MP_W   = 53;
   localparam int CHUNK  = 16;
   localparam int KW     = 3 * CHUNK;
   localparam int RW     = 36;
   localparam int IW     = RW + 2;

   localparam int SAT_MAX = (1 << (SAMPLE_BITS - 1)) - 1;

   localparam logic signed [CW-1:0] INV_GAIN    = CW'(652032874);
   localparam logic signed [CW-1:0] HALF_WIDE   = CW'(1) <<< (PHASE_BITS - 1);
   localparam logic signed [CW-1:0] HALF_NARROW = CW'(1) <<< (PHASE_BITS - 2);

   // loop gain constants, q.16
   localparam logic signed [MB_W-1:0] CP_Q16 = MB_W'(174719);
   localparam logic signed [MB_W-1:0] CI_Q16 = MB_W'(232980);

   // integrator limits
   localparam logic signed [PHASE_BITS-1:0] INT_MAX = {1'b0, {(PHASE_BITS-1){1'b1}}};
   localparam logic signed [PHASE_BITS-1:0] INT_MIN = {1'b1, {(PHASE_BITS-1){1'b0}}};

   // csr register indexes
   localparam logic [CSR_A_W-1:0] CSR_PHASE_STEP   = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_LOOP_BW      = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_SCALE_HALVES = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_PHASE_ADJUST = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MIX_I,
      ST_MIX_Q,
      ST_BW_SQ,
      ST_BW_WAIT,
      ST_KI_MUL,
      ST_KI_WAIT,
      ST_KI_ROUND,
      ST_KP_GAIN,
      ST_VEC_RUN,
      ST_PK0,
      ST_PK1,
      ST_PK2,
      ST_IK0,
      ST_IK1,
      ST_IK2,
      ST_IK_WAIT,
      ST_UPDATE,
      ST_FB_START,
      ST_FB_RUN,
      ST_OUT_START,
      ST_OUT_RUN,
      ST_FINISH
   } seq_state_type;

   typedef enum logic [1:0] {
      MAC_IDLE,
      MAC_LOAD,
      MAC_SHIFT_ADD
   } mac_mode_type;

   typedef struct packed {
      logic start;
      logic vectoring;
      logic full_turn;
   } cordic_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_stat_type;

   // atan(2^-i), 2^32 per turn
   function automatic logic [31:0] atan_turn32(input logic [STEP_BITS-1:0] idx);
      logic [31:0] t;
      case (idx)
         4'd0:    t = 32'd536870912;
         4'd1:    t = 32'd316933406;
         4'd2:    t = 32'd167458907;
         4'd3:    t = 32'd85004756;
         4'd4:    t = 32'd42667331;
         4'd5:    t = 32'd21354465;
         4'd6:    t = 32'd10679838;
         4'd7:    t = 32'd5340245;
         4'd8:    t = 32'd2670163;
         4'd9:    t = 32'd1335087;
         4'd10:   t = 32'd667544;
         4'd11:   t = 32'd333772;
         4'd12:   t = 32'd166886;
         4'd13:   t = 32'd83443;
         4'd14:   t = 32'd41722;
         4'd15:   t = 32'd20861;
         default: t = 32'd0;
      endcase
      return t;
   endfunction

endpackage

>>> design/pllnco_mac.sv
// shared multiplier with a registered product and a shift-accumulate register
module pllnco_mac (
   input  logic                                      clock,
   input  logic                                      reset,
   input  pllnco_pkg::mac_mode_type                  mode,
   input  logic signed [pllnco_pkg::MA_W-1:0]        op_a,
   input  logic signed [pllnco_pkg::MB_W-1:0]        op_b,
   output logic signed [pllnco_pkg::MP_W-1:0]        acc
);

   logic signed [pllnco_pkg::MP_W-1:0] prod_ff;
   logic signed [pllnco_pkg::MP_W-1:0] prod_in;
   logic signed [pllnco_pkg::MP_W-1:0] acc_ff;
   logic signed [pllnco_pkg::MP_W-1:0] acc_in;
   pllnco_pkg::mac_mode_type           mode_ff;

   // multiplier stage
   assign prod_in = op_a * op_b;

   // accumulate stage, the shift keeps only the bits above each chunk
   always_comb begin
      case (mode_ff)
         pllnco_pkg::MAC_LOAD:      acc_in = prod_ff;
         pllnco_pkg::MAC_SHIFT_ADD: acc_in = (acc_ff >>> pllnco_pkg::CHUNK) + prod_ff;
         default:                   acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pllnco_pkg::MAC_IDLE;
      end else begin
         mode_ff <= mode;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

>>> design/pllnco_cordic.sv
// iterative cordic, vectoring (atan2) and rotation (cos/sin) in one shared unit
module pllnco_cordic (
   input  logic                                          clock,
   input  logic                                          reset,
   input  pllnco_pkg::cordic_cmd_type                    cmd,
   input  logic signed [pllnco_pkg::CW-1:0]              x_in,
   input  logic signed [pllnco_pkg::CW-1:0]              y_in,
   input  logic [pllnco_pkg::PHASE_BITS-1:0]             angle_in,
   output pllnco_pkg::cordic_stat_type                   stat,
   output logic signed [pllnco_pkg::CW-1:0]              angle_out,
   output logic signed [pllnco_pkg::SAMPLE_BITS-1:0]     cos_out,
   output logic signed [pllnco_pkg::SAMPLE_BITS-1:0]     sin_out
);

   localparam logic [pllnco_pkg::STEP_BITS-1:0] LAST_STEP =
      pllnco_pkg::STEP_BITS'(pllnco_pkg::CORDIC_STEPS - 1);

   // round q2.30 to a sample and saturate symmetrically
   function automatic logic signed [pllnco_pkg::SAMPLE_BITS-1:0] to_sample(
      input logic signed [pllnco_pkg::CW-1:0] q);
      logic signed [pllnco_pkg::CW-1:0] r;
      r = (q + (pllnco_pkg::CW'(1) <<< (30 - pllnco_pkg::SAMPLE_BITS)))
          >>> (31 - pllnco_pkg::SAMPLE_BITS);
      if (r > pllnco_pkg::CW'(pllnco_pkg::SAT_MAX)) begin
         r = pllnco_pkg::CW'(pllnco_pkg::SAT_MAX);
      end else if (r < -pllnco_pkg::CW'(pllnco_pkg::SAT_MAX)) begin
         r = -pllnco_pkg::CW'(pllnco_pkg::SAT_MAX);
      end
      return r[pllnco_pkg::SAMPLE_BITS-1:0];
   endfunction

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [pllnco_pkg::STEP_BITS-1:0]      cnt_ff, cnt_in;
   logic                                  vec_ff, vec_in;
   logic                                  full_ff, full_in;
   logic                                  neg_ff, neg_in;
   logic                                  zero_ff, zero_in;
   logic signed [pllnco_pkg::CW-1:0]      x_ff, x_in_r;
   logic signed [pllnco_pkg::CW-1:0]      y_ff, y_in_r;
   logic signed [pllnco_pkg::CW-1:0]      z_ff, z_in;

   logic signed [pllnco_pkg::CW-1:0]      half_v, quarter_v, one_v;
   logic signed [pllnco_pkg::CW-1:0]      za, zf, rz0, vx0, vy0, vz0;
   logic                                  rneg0;
   logic signed [pllnco_pkg::CW-1:0]      xs, ys, atan_v, xo, yo;
   logic                                  ccw;

   // start values for both modes
   always_comb begin
      half_v    = cmd.full_turn ? pllnco_pkg::HALF_WIDE : pllnco_pkg::HALF_NARROW;
      quarter_v = half_v >>> 1;
      one_v     = half_v <<< 1;
      za = cmd.full_turn
         ? {{(pllnco_pkg::CW-pllnco_pkg::PHASE_BITS){1'b0}}, angle_in}
         : {{(pllnco_pkg::CW-pllnco_pkg::PHASE_BITS+1){1'b0}},
            angle_in[pllnco_pkg::PHASE_BITS-2:0]};
      zf = (za >= half_v) ? za - one_v : za;
      // fold into the right half plane
      if (zf > quarter_v) begin
         rz0   = zf - half_v;
         rneg0 = 1'b1;
      end else if (zf < -quarter_v) begin
         rz0   = zf + half_v;
         rneg0 = 1'b1;
      end else begin
         rz0   = zf;
         rneg0 = 1'b0;
      end
      // vectoring pre-rotation by a half turn when x is negative
      if (x_in < 0) begin
         vx0 = -x_in;
         vy0 = -y_in;
         vz0 = (y_in >= 0) ? half_v : -half_v;
      end else begin
         vx0 = x_in;
         vy0 = y_in;
         vz0 = '0;
      end
   end

   // one micro-rotation per cycle
   always_comb begin
      xs     = x_ff >>> cnt_ff;
      ys     = y_ff >>> cnt_ff;
      atan_v = full_ff
         ? pllnco_pkg::CW'(pllnco_pkg::atan_turn32(cnt_ff))
         : (pllnco_pkg::CW'(pllnco_pkg::atan_turn32(cnt_ff)) + pllnco_pkg::CW'(1)) >>> 1;
      ccw    = vec_ff ? !(y_ff > 0) : (z_ff >= 0);
   end

   // sequencing of the iterations
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      vec_in  = vec_ff;
      full_in = full_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      x_in_r  = x_ff;
      y_in_r  = y_ff;
      z_in    = z_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         vec_in  = cmd.vectoring;
         full_in = cmd.full_turn;
         if (cmd.vectoring) begin
            neg_in  = 1'b0;
            zero_in = (x_in == 0) && (y_in == 0);
            x_in_r  = vx0;
            y_in_r  = vy0;
            z_in    = vz0;
         end else begin
            neg_in  = rneg0;
            zero_in = 1'b0;
            x_in_r  = pllnco_pkg::INV_GAIN;
            y_in_r  = '0;
            z_in    = rz0;
         end
      end else if (busy_ff) begin
         if (ccw) begin
            x_in_r = x_ff - ys;
            y_in_r = y_ff + xs;
            z_in   = z_ff - atan_v;
         end else begin
            x_in_r = x_ff + ys;
            y_in_r = y_ff - xs;
            z_in   = z_ff + atan_v;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         vec_ff  <= 1'b0;
         full_ff <= 1'b0;
         neg_ff  <= 1'b0;
         zero_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         vec_ff  <= vec_in;
         full_ff <= full_in;
         neg_ff  <= neg_in;
         zero_ff <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in_r;
      y_ff <= y_in_r;
      z_ff <= z_in;
   end

   // results
   assign xo        = neg_ff ? -x_ff : x_ff;
   assign yo        = neg_ff ? -y_ff : y_ff;
   assign cos_out   = to_sample(xo);
   assign sin_out   = to_sample(yo);
   assign angle_out = zero_ff ? '0 : z_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

>>> design/pilot_pll_with_scaled_nco.sv
// top level: sequencer, loop filter and nco state of the pilot pll
//
// Tracks a real pilot tone one sample at a time with a second-order loop and
// returns, for each request, the scaled nco cosine computed on the previous
// request (the first one after reset is 32767). Each sample makes three passes
// through the single shared cordic unit (phase detector arctangent, feedback
// sine/cosine and output cosine), each a start, 16 micro-rotations and a done
// step, plus multiply steps on the shared multiplier, the loop update and the
// finishing step; a new sample is not taken before the last one is through.
// req_tready is high only while the sequencer is idle; a finished result
// waits in the output register and does not hold off the next request, but if
// it is still waiting when the next result is done the sequencer holds in its
// finishing step. Configuration is written through csr_*; a write while idle
// takes effect on the next request; a write during a sequence may already affect
// the request in progress.
module pilot_pll_with_scaled_nco (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel, tdata: sample[15:0]
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [15:0]                             req_tdata,
   // result channel, tdata: nco_out[15:0]
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [15:0]                             rsp_tdata,
   // configuration write port
   input  logic                                    csr_we,
   input  logic [pllnco_pkg::CSR_A_W-1:0]          csr_addr,
   input  logic [pllnco_pkg::CSR_W-1:0]            csr_wdata
);

   pllnco_pkg::seq_state_type state_ff, state_in;

   // configuration
   logic [pllnco_pkg::STEP_W-1:0]   step_ff;
   logic [pllnco_pkg::BW_W-1:0]     bw_ff;
   logic [pllnco_pkg::SCALE_W-1:0]  scale_ff;
   logic [pllnco_pkg::ADJUST_W-1:0] adjust_ff;

   // loop state
   logic [pllnco_pkg::PHASE_BITS-1:0]           nco_ff, nco_in;
   logic [pllnco_pkg::PHASE_BITS-1:0]           pe_ff, pe_in;
   logic signed [pllnco_pkg::PHASE_BITS-1:0]    li_ff, li_in;
   logic signed [pllnco_pkg::SAMPLE_BITS-1:0]   fb_cos_ff, fb_sin_ff;
   logic signed [pllnco_pkg::SAMPLE_BITS-1:0]   held_ff;

   // working registers
   logic signed [pllnco_pkg::SAMPLE_BITS-1:0]   sample_ff;
   logic signed [pllnco_pkg::CW-1:0]            prodi_ff, prodq_ff;
   logic [pllnco_pkg::KW-1:0]                   kp_ff, ki_ff;
   logic                                        err_neg_ff;
   logic [pllnco_pkg::PHASE_BITS-1:0]           err_mag_ff;
   logic [pllnco_pkg::RW-1:0]                   rp_ff;
   logic [pllnco_pkg::PHASE_BITS-1:0]           theta_ff;

   // result register
   logic                                        rsp_valid_ff, rsp_valid_in;
   logic [15:0]                                 rsp_data_ff;

   // shared units
   pllnco_pkg::mac_mode_type                    mac_mode;
   logic signed [pllnco_pkg::MA_W-1:0]          mac_a;
   logic signed [pllnco_pkg::MB_W-1:0]          mac_b;
   logic signed [pllnco_pkg::MP_W-1:0]          mac_acc;
   pllnco_pkg::cordic_cmd_type                  cor_cmd;
   pllnco_pkg::cordic_stat_type                 cor_stat;
   logic [pllnco_pkg::PHASE_BITS-1:0]           cor_angle_in;
   logic signed [pllnco_pkg::CW-1:0]            cor_angle;
   logic signed [pllnco_pkg::SAMPLE_BITS-1:0]   cor_cos, cor_sin;

   logic                                        req_accept;
   logic                                        out_free;
   logic signed [pllnco_pkg::CW-1:0]            err_abs;
   logic [pllnco_pkg::MP_W-1:0]                 ki_round;
   logic signed [pllnco_pkg::IW-1:0]            ri_signed, integ_sum;
   logic signed [pllnco_pkg::PHASE_BITS-1:0]    integ_sat;
   logic [pllnco_pkg::PHASE_BITS-1:0]           rp_signed;
   logic [pllnco_pkg::PHASE_BITS-1:0]           outph;

   pllnco_mac u_mac (
      .clock (clock),
      .reset (reset),
      .mode  (mac_mode),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   pllnco_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cor_cmd),
      .x_in      (prodi_ff),
      .y_in      (prodq_ff),
      .angle_in  (cor_angle_in),
      .stat      (cor_stat),
      .angle_out (cor_angle),
      .cos_out   (cor_cos),
      .sin_out   (cor_sin)
   );

   assign req_tready = (state_ff == pllnco_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pllnco_pkg::ST_IDLE:      if (req_accept) state_in = pllnco_pkg::ST_MIX_I;
         pllnco_pkg::ST_MIX_I:     state_in = pllnco_pkg::ST_MIX_Q;
         pllnco_pkg::ST_MIX_Q:     state_in = pllnco_pkg::ST_BW_SQ;
         pllnco_pkg::ST_BW_SQ:     state_in = pllnco_pkg::ST_BW_WAIT;
         pllnco_pkg::ST_BW_WAIT:   state_in = pllnco_pkg::ST_KI_MUL;
         pllnco_pkg::ST_KI_MUL:    state_in = pllnco_pkg::ST_KI_WAIT;
         pllnco_pkg::ST_KI_WAIT:   state_in = pllnco_pkg::ST_KI_ROUND;
         pllnco_pkg::ST_KI_ROUND:  state_in = pllnco_pkg::ST_KP_GAIN;
         pllnco_pkg::ST_KP_GAIN:   state_in = pllnco_pkg::ST_VEC_RUN;
         pllnco_pkg::ST_VEC_RUN:   if (cor_stat.done) state_in = pllnco_pkg::ST_PK0;
         pllnco_pkg::ST_PK0:       state_in = pllnco_pkg::ST_PK1;
         pllnco_pkg::ST_PK1:       state_in = pllnco_pkg::ST_PK2;
         pllnco_pkg::ST_PK2:       state_in = pllnco_pkg::ST_IK0;
         pllnco_pkg::ST_IK0:       state_in = pllnco_pkg::ST_IK1;
         pllnco_pkg::ST_IK1:       state_in = pllnco_pkg::ST_IK2;
         pllnco_pkg::ST_IK2:       state_in = pllnco_pkg::ST_IK_WAIT;
         pllnco_pkg::ST_IK_WAIT:   state_in = pllnco_pkg::ST_UPDATE;
         pllnco_pkg::ST_UPDATE:    state_in = pllnco_pkg::ST_FB_START;
         pllnco_pkg::ST_FB_START:  state_in = pllnco_pkg::ST_FB_RUN;
         pllnco_pkg::ST_FB_RUN:    if (cor_stat.done) state_in = pllnco_pkg::ST_OUT_START;
         pllnco_pkg::ST_OUT_START: state_in = pllnco_pkg::ST_OUT_RUN;
         pllnco_pkg::ST_OUT_RUN:   if (cor_stat.done) state_in = pllnco_pkg::ST_FINISH;
         pllnco_pkg::ST_FINISH:    if (out_free) state_in = pllnco_pkg::ST_IDLE;
         default:                  state_in = pllnco_pkg::ST_IDLE;
      endcase
   end

   // output phase: theta times the half-scale plus the offset, mod a turn
   assign outph = theta_ff * pllnco_pkg::PHASE_BITS'(scale_ff)
                + {adjust_ff, {(pllnco_pkg::PHASE_BITS-pllnco_pkg::ADJUST_W){1'b0}}};

   // commands to the shared units
   always_comb begin
      mac_mode          = pllnco_pkg::MAC_IDLE;
      mac_a             = '0;
      mac_b             = '0;
      cor_cmd.start     = 1'b0;
      cor_cmd.vectoring = 1'b0;
      cor_cmd.full_turn = 1'b0;
      cor_angle_in      = '0;
      unique case (state_ff)
         pllnco_pkg::ST_MIX_I: begin
            mac_mode = pllnco_pkg::MAC_LOAD;
            mac_a    = pllnco_pkg::MA_W'(sample_ff);
            mac_b    = pllnco_pkg::MB_W'(fb_cos_ff);
         end
         pllnco_pkg::ST_MIX_Q: begin
            mac_mode = pllnco_pkg::MAC_LOAD;
            mac_a    = pllnco_pkg::MA_W'(sample_ff);
            mac_b    = pllnco_pkg::MB_W'(fb_sin_ff);
         end
         pllnco_pkg::ST_BW_SQ: begin
            mac_mode = pllnco_pkg::MAC_LOAD;
            mac_a    = {{(pllnco_pkg::MA_W-pllnco_pkg::BW_W){1'b0}}, bw_ff};
            mac_b    = {{(pllnco_pkg::MB_W-pllnco_pkg::BW_W){1'b0}}, bw_ff};
         end
         pllnco_pkg::ST_KI_MUL: begin
            mac_mode = pllnco_pkg::MAC_LOAD;
            mac_a    = {{(pllnco_pkg::MA_W-32){1'b0}}, mac_acc[31:0]};
            mac_b    = pllnco_pkg::CI_Q16;
         end
         pllnco_pkg::ST_KI_WAIT: begin
            mac_mode = pllnco_pkg::MAC_LOAD;
            mac_a    = {{(pllnco_pkg::MA_W-pllnco_pkg::BW_W){1'b0}}, bw_ff};
            mac_b    = pllnco_pkg::CP_Q16;
         end
         pllnco_pkg::ST_KP_GAIN: begin
            cor_cmd.start     = 1'b1;
            cor_cmd.vectoring = 1'b1;
         end
         pllnco_pkg::ST_PK0, pllnco_pkg::ST_PK1, pllnco_pkg::ST_PK2,
         pllnco_pkg::ST_IK0, pllnco_pkg::ST_IK1, pllnco_pkg::ST_IK2: begin
            mac_a = {{(pllnco_pkg::MA_W-pllnco_pkg::PHASE_BITS){1'b0}}, err_mag_ff};
            if (state_ff == pllnco_pkg::ST_PK0 || state_ff == pllnco_pkg::ST_IK0) begin
               mac_mode = pllnco_pkg::MAC_LOAD;
            end else begin
               mac_mode = pllnco_pkg::MAC_SHIFT_ADD;
            end
            case (state_ff)
               pllnco_pkg::ST_PK0: mac_b = {3'b000, kp_ff[0 +: pllnco_pkg::CHUNK]};
               pllnco_pkg::ST_PK1: mac_b = {3'b000, kp_ff[pllnco_pkg::CHUNK +: pllnco_pkg::CHUNK]};
               pllnco_pkg::ST_PK2: mac_b = {3'b000, kp_ff[2*pllnco_pkg::CHUNK +: pllnco_pkg::CHUNK]};
               pllnco_pkg::ST_IK0: mac_b = {3'b000, ki_ff[0 +: pllnco_pkg::CHUNK]};
               pllnco_pkg::ST_IK1: mac_b = {3'b000, ki_ff[pllnco_pkg::CHUNK +: pllnco_pkg::CHUNK]};
               default:            mac_b = {3'b000, ki_ff[2*pllnco_pkg::CHUNK +: pllnco_pkg::CHUNK]};
            endcase
         end
         pllnco_pkg::ST_FB_START: begin
            cor_cmd.start = 1'b1;
            cor_angle_in  = nco_ff + pe_ff;
         end
         pllnco_pkg::ST_OUT_START: begin
            cor_cmd.start     = 1'b1;
            cor_cmd.full_turn = 1'b1;
            cor_angle_in      = outph;
         end
         default: begin
            mac_mode = pllnco_pkg::MAC_IDLE;
         end
      endcase
   end

   // loop filter arithmetic
   always_comb begin
      err_abs   = (cor_angle < 0) ? -cor_angle : cor_angle;
      ki_round  = mac_acc + pllnco_pkg::MP_W'(32768);
      ri_signed = err_neg_ff ? -pllnco_pkg::IW'(mac_acc[pllnco_pkg::RW-1:0])
                             :  pllnco_pkg::IW'(mac_acc[pllnco_pkg::RW-1:0]);
      integ_sum = pllnco_pkg::IW'(li_ff) + ri_signed;
      if (integ_sum > pllnco_pkg::IW'(pllnco_pkg::INT_MAX)) begin
         integ_sat = pllnco_pkg::INT_MAX;
      end else if (integ_sum < pllnco_pkg::IW'(pllnco_pkg::INT_MIN)) begin
         integ_sat = pllnco_pkg::INT_MIN;
      end else begin
         integ_sat = integ_sum[pllnco_pkg::PHASE_BITS-1:0];
      end
      rp_signed = err_neg_ff ? -rp_ff[pllnco_pkg::PHASE_BITS-1:0]
                             :  rp_ff[pllnco_pkg::PHASE_BITS-1:0];
      li_in  = li_ff;
      pe_in  = pe_ff;
      nco_in = nco_ff;
      if (state_ff == pllnco_pkg::ST_UPDATE) begin
         li_in  = integ_sat;
         pe_in  = pe_ff + rp_signed + integ_sat;
         nco_in = nco_ff + {1'b0, step_ff};
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == pllnco_pkg::ST_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pllnco_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         nco_ff       <= '0;
         pe_ff        <= '0;
         li_ff        <= '0;
         fb_cos_ff    <= pllnco_pkg::SAMPLE_BITS'(pllnco_pkg::SAT_MAX);
         fb_sin_ff    <= '0;
         held_ff      <= pllnco_pkg::SAMPLE_BITS'(pllnco_pkg::SAT_MAX);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         nco_ff       <= nco_in;
         pe_ff        <= pe_in;
         li_ff        <= li_in;
         if (state_ff == pllnco_pkg::ST_OUT_START) begin
            fb_cos_ff <= cor_cos;
            fb_sin_ff <= cor_sin;
         end
         if (state_ff == pllnco_pkg::ST_FINISH && out_free) begin
            held_ff <= cor_cos;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= '0;
         bw_ff     <= pllnco_pkg::BW_W'(655);
         scale_ff  <= pllnco_pkg::SCALE_W'(2);
         adjust_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            pllnco_pkg::CSR_PHASE_STEP:   step_ff   <= csr_wdata[pllnco_pkg::STEP_W-1:0];
            pllnco_pkg::CSR_LOOP_BW:      bw_ff     <= csr_wdata[pllnco_pkg::BW_W-1:0];
            pllnco_pkg::CSR_SCALE_HALVES: scale_ff  <= csr_wdata[pllnco_pkg::SCALE_W-1:0];
            pllnco_pkg::CSR_PHASE_ADJUST: adjust_ff <= csr_wdata[pllnco_pkg::ADJUST_W-1:0];
            default:                      step_ff   <= step_ff;
         endcase
      end
   end

   // working registers, loaded by step
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_tdata;
      end
      if (state_ff == pllnco_pkg::ST_BW_SQ) begin
         prodi_ff <= mac_acc[pllnco_pkg::CW-1:0];
      end
      if (state_ff == pllnco_pkg::ST_BW_WAIT) begin
         prodq_ff <= -mac_acc[pllnco_pkg::CW-1:0];
      end
      if (state_ff == pllnco_pkg::ST_KI_ROUND) begin
         ki_ff <= pllnco_pkg::KW'(ki_round[pllnco_pkg::MP_W-1:16]);
      end
      if (state_ff == pllnco_pkg::ST_KP_GAIN) begin
         kp_ff <= mac_acc[pllnco_pkg::KW-1:0];
      end
      if (state_ff == pllnco_pkg::ST_VEC_RUN && cor_stat.done) begin
         err_neg_ff <= (cor_angle < 0);
         err_mag_ff <= err_abs[pllnco_pkg::PHASE_BITS-1:0];
      end
      // the proportional product is complete once its last chunk has passed the product and accumulate registers
      if (state_ff == pllnco_pkg::ST_IK1) begin
         rp_ff <= mac_acc[pllnco_pkg::RW-1:0];
      end
      if (state_ff == pllnco_pkg::ST_FB_START) begin
         theta_ff <= nco_ff + pe_ff;
      end
      if (state_ff == pllnco_pkg::ST_FINISH && out_free) begin
         rsp_data_ff <= held_ff;
      end
   end

   // a request always starts the mixer step
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == pllnco_pkg::ST_MIX_I))
      else $error("request did not start the sequence");

   // a result appears only out of the finishing step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == pllnco_pkg::ST_FINISH))
      else $error("result raised outside the finishing step");

   // the shared cordic is never restarted while it iterates
   assert property (@(posedge clock) disable iff (reset)
      cor_cmd.start |-> !cor_stat.busy)
      else $error("cordic started while busy");

endmodule
